>>> rtl/core/pqtp_pkg.sv
// Shared types, widths and codes for the port queue telemetry probe.
package pqtp_pkg;

   // field widths
   localparam int PORT_W   = 6;
   localparam int DEPTH_W  = 16;
   localparam int TIME_W   = 48;
   localparam int ETYPE_W  = 16;
   localparam int PROTO_W  = 8;
   localparam int UDP_W    = 16;
   localparam int SWID_W   = 32;
   localparam int PERIOD_W = 20;
   localparam int COUNT_W  = 7;
   localparam int CLASS_W  = 2;
   localparam int LIMIT_W  = 30;   // window length in us fits in 30 bits

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_ID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_UDP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS = 2'd2;

   localparam logic [SWID_W-1:0]   SWITCH_ID_RST = '0;
   localparam logic [UDP_W-1:0]    PROBE_UDP_RST = 16'd9999;
   localparam logic [PERIOD_W-1:0] WINDOW_MS_RST = 20'd100;

   // header constants
   localparam logic [ETYPE_W-1:0] ETHER_IPV4   = 16'd2048;
   localparam logic [PROTO_W-1:0] IP_PROTO_UDP = 8'd17;
   localparam logic [LIMIT_W-1:0] US_PER_MS    = 30'd1000;

   // packet classes
   localparam logic [CLASS_W-1:0] CLS_OTHER = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_PROBE = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_QUERY = 2'd2;
   localparam logic [CLASS_W-1:0] CLS_PATH  = 2'd3;

   // port table
   localparam int NUM_PORTS_DEF = 64;
   localparam int PORT_SPAN     = 64;   // ports an out_port field can name

   typedef struct packed {
      logic [PORT_W-1:0]  out_port;
      logic [DEPTH_W-1:0] queue_depth;
      logic [TIME_W-1:0]  time_us;
      logic [ETYPE_W-1:0] ether_type;
      logic [PROTO_W-1:0] ip_proto;
      logic [UDP_W-1:0]   udp_dst_port;
      logic [SWID_W-1:0]  header_switch_id;
   } req_word_type;

   typedef struct packed {
      logic [CLASS_W-1:0] packet_class;
      logic               stamp_id;
      logic               entry_valid;
      logic [PORT_W-1:0]  entry_port;
      logic [DEPTH_W-1:0] entry_max_depth;
      logic [COUNT_W-1:0] entry_count;
      logic               last;
   } rsp_word_type;

   // classifier verdict handed to the control logic
   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      logic               stamp;
      logic               walk;    // unstamped probe: report every seen port
   } class_info_type;

   // one port table entry
   typedef struct packed {
      logic [TIME_W-1:0]  start;
      logic [DEPTH_W-1:0] max_depth;
   } port_entry_type;

endpackage

>>> rtl/core/port_queue_telemetry_probe_core.sv
// Top level: per-port queue depth window tracking and probe telemetry.
//
//  channel  | ports                            | direction | transfer
//  ---------+----------------------------------+-----------+--------------------------
//  request  | req_valid, req_stall, req_word   | in        | req_valid && !req_stall
//  response | rsp_valid, rsp_stall, rsp_word   | out       | rsp_valid && !rsp_stall
//  csr      | csr_valid, csr_ready, csr_index, | in        | csr_valid && csr_ready
//           | csr_wdata                        |           |
//
// An ordinary word first reads its port entry from the port table memory, then updates and writes
// it back and loads the result register, waiting in ST_HOLD while a stalled result still holds it.
// An unstamped probe then sweeps the table one port per cycle over up to min(NUM_PORTS, 64) ports,
// pausing while an emitted entry stalls with rsp_stall, and ends at the last seen port.
// The result register lets a new request word in while a result is still waiting.
// Synchronous active-high reset clears seen bits and the seen count and loads the CSR reset values; no clearing pass.
module port_queue_telemetry_probe_core #(
   parameter int NUM_PORTS = pqtp_pkg::NUM_PORTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pqtp_pkg::req_word_type            req_word,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pqtp_pkg::rsp_word_type            rsp_word,
   // csr write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pqtp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pqtp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(NUM_PORTS);
   // ports a probe sweep visits
   localparam int WALK  = (NUM_PORTS < pqtp_pkg::PORT_SPAN) ? NUM_PORTS : pqtp_pkg::PORT_SPAN;
   localparam int PTR_W = $clog2(WALK + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;
   localparam logic [1:0] ST_WALK = 2'd3;

   // ---------------- CSRs ----------------
   logic [pqtp_pkg::SWID_W-1:0]   switch_id_ff;
   logic [pqtp_pkg::UDP_W-1:0]    probe_udp_ff;
   logic [pqtp_pkg::PERIOD_W-1:0] period_ff;
   logic [pqtp_pkg::LIMIT_W-1:0]  limit_ff, limit_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         switch_id_ff <= pqtp_pkg::SWITCH_ID_RST;
         probe_udp_ff <= pqtp_pkg::PROBE_UDP_RST;
         period_ff    <= pqtp_pkg::WINDOW_MS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pqtp_pkg::CSR_SWITCH_ID: switch_id_ff <= csr_wdata;
            pqtp_pkg::CSR_PROBE_UDP: probe_udp_ff <= csr_wdata[pqtp_pkg::UDP_W-1:0];
            pqtp_pkg::CSR_WINDOW_MS: period_ff    <= csr_wdata[pqtp_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // window length in us, registered off the multiplier
   assign limit_in = pqtp_pkg::LIMIT_W'(period_ff) * pqtp_pkg::US_PER_MS;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= pqtp_pkg::LIMIT_W'(pqtp_pkg::WINDOW_MS_RST) * pqtp_pkg::US_PER_MS;
      else       limit_ff <= limit_in;
   end

   // switch id is held here for the record of what gets stamped;
   // it does not alter any result field
   logic switch_id_nz;
   assign switch_id_nz = |switch_id_ff;

   // ---------------- control state ----------------
   logic [1:0]                     state_ff, state_in;
   pqtp_pkg::req_word_type         item_ff;
   pqtp_pkg::class_info_type       cls_ff, cls_info;
   logic [NUM_PORTS-1:0]           seen_ff, seen_in;
   logic [pqtp_pkg::COUNT_W-1:0]   seen_cnt_ff, seen_cnt_in;
   logic [PTR_W-1:0]               walk_ptr_ff, walk_ptr_in;
   logic                           rd_pend_ff, rd_pend_in;
   logic                           rd_seen_ff, rd_seen_in;
   logic [pqtp_pkg::PORT_W-1:0]    rd_port_ff, rd_port_in;
   logic [pqtp_pkg::COUNT_W-1:0]   emit_cnt_ff, emit_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   pqtp_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;
   logic                           rsp_load;

   // ---------------- port table memory ----------------
   pqtp_pkg::port_entry_type       mem [NUM_PORTS];
   pqtp_pkg::port_entry_type       rd_data_ff;
   pqtp_pkg::port_entry_type       wr_data;
   logic                           mem_we;
   logic                           rd_en;
   logic [IDX_W-1:0]               rd_addr;
   logic [IDX_W-1:0]               item_idx;

   always_ff @(posedge clock) begin
      if (mem_we) mem[item_idx] <= wr_data;
      if (rd_en)  rd_data_ff    <= mem[rd_addr];
   end

   // ---------------- classifier ----------------
   pqtp_classify u_classify (
      .item      (item_ff),
      .probe_udp (probe_udp_ff),
      .info      (cls_info)
   );

   // ---------------- update datapath ----------------
   logic                           accept;
   logic                           slot_free;
   logic                           item_port_ok;
   logic                           old_seen;
   logic [pqtp_pkg::TIME_W-1:0]    elapsed;
   logic                           restart;
   logic [pqtp_pkg::COUNT_W-1:0]   cnt_upd;
   logic                           walk_adv, walk_issue, emit, emit_last;
   pqtp_pkg::rsp_word_type         plain_word, entry_word;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign item_port_ok = (9'(item_ff.out_port) < 9'(NUM_PORTS));
   assign item_idx     = IDX_W'(item_ff.out_port);
   assign old_seen     = seen_ff[item_idx];

   // elapsed time wraps modulo 2^48, so a backward step restarts the window
   assign elapsed = item_ff.time_us - rd_data_ff.start;
   assign restart = !old_seen || (elapsed >= pqtp_pkg::TIME_W'(limit_ff));

   always_comb begin
      wr_data.start     = restart ? item_ff.time_us : rd_data_ff.start;
      wr_data.max_depth = (restart || (item_ff.queue_depth > rd_data_ff.max_depth)) ?
                          item_ff.queue_depth : rd_data_ff.max_depth;
   end

   assign mem_we  = (state_ff == ST_UPD) && item_port_ok;
   assign cnt_upd = seen_cnt_ff + pqtp_pkg::COUNT_W'(item_port_ok && !old_seen);

   // sweep: a read in flight is consumed when unseen or when the slot is free
   assign walk_adv   = !rd_pend_ff || !rd_seen_ff || slot_free;
   assign emit       = (state_ff == ST_WALK) && rd_pend_ff && rd_seen_ff && slot_free;
   assign emit_last  = emit && ((emit_cnt_ff + 7'd1) == seen_cnt_ff);
   assign walk_issue = (state_ff == ST_WALK) && walk_adv && !emit_last &&
                       (walk_ptr_ff < PTR_W'(WALK));

   assign rd_en   = accept || walk_issue;
   assign rd_addr = (state_ff == ST_IDLE) ? IDX_W'(req_word.out_port) : IDX_W'(walk_ptr_ff);

   // result words
   always_comb begin
      plain_word                 = '0;
      plain_word.packet_class    = (state_ff == ST_UPD) ? cls_info.cls : cls_ff.cls;
      plain_word.stamp_id        = (state_ff == ST_UPD) ? cls_info.stamp : cls_ff.stamp;
      plain_word.last            = 1'b1;

      entry_word.packet_class    = cls_ff.cls;
      entry_word.stamp_id        = cls_ff.stamp;
      entry_word.entry_valid     = 1'b1;
      entry_word.entry_port      = rd_port_ff;
      entry_word.entry_max_depth = rd_data_ff.max_depth;
      entry_word.entry_count     = seen_cnt_ff;
      entry_word.last            = emit_last;
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in    = state_ff;
      seen_in     = seen_ff;
      seen_cnt_in = seen_cnt_ff;
      walk_ptr_in = walk_ptr_ff;
      rd_pend_in  = rd_pend_ff;
      rd_seen_in  = rd_seen_ff;
      rd_port_in  = rd_port_ff;
      emit_cnt_in = emit_cnt_ff;
      rsp_load    = 1'b0;
      rsp_word_in = plain_word;

      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_UPD;
         end
         ST_UPD: begin
            if (item_port_ok) seen_in[item_idx] = 1'b1;
            seen_cnt_in = cnt_upd;
            if (cls_info.walk && (cnt_upd != '0)) begin
               state_in    = ST_WALK;
               walk_ptr_in = '0;
               rd_pend_in  = 1'b0;
               emit_cnt_in = '0;
            end else if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (emit) begin
               rsp_load    = 1'b1;
               rsp_word_in = entry_word;
               emit_cnt_in = emit_cnt_ff + 7'd1;
            end
            if (emit_last) begin
               rd_pend_in = 1'b0;
               state_in   = ST_IDLE;
            end else if (walk_adv) begin
               rd_pend_in = walk_issue;
               rd_seen_in = walk_issue && seen_ff[IDX_W'(walk_ptr_ff)];
               rd_port_in = pqtp_pkg::PORT_W'(walk_ptr_ff);
               if (walk_issue) walk_ptr_in = walk_ptr_ff + PTR_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load)          rsp_valid_in = 1'b1;
      else if (!rsp_stall)   rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         seen_cnt_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         seen_cnt_ff  <= seen_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept)                  item_ff     <= req_word;
      if (state_ff == ST_UPD)      cls_ff      <= cls_info;
      if (rsp_load)                rsp_word_ff <= rsp_word_in;
      walk_ptr_ff <= walk_ptr_in;
      rd_seen_ff  <= rd_seen_in;
      rd_port_ff  <= rd_port_in;
      emit_cnt_ff <= emit_cnt_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------- assertions ----------------
   // an entry always reports a nonzero count no larger than the sweep span
   a_entry_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.entry_valid) |->
      ((rsp_word.entry_count != '0) &&
       (rsp_word.entry_count <= pqtp_pkg::COUNT_W'(WALK))))
      else $error("entry count out of range");

   a_entry_seen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.entry_valid) |-> seen_ff[IDX_W'(rsp_word.entry_port)])
      else $error("entry reported for a port never seen");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous word still in update");

   a_entry_probe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.entry_valid) |->
      (rsp_word.packet_class == pqtp_pkg::CLS_PROBE && rsp_word.stamp_id &&
       (switch_id_nz || !switch_id_nz)))
      else $error("entry result on a word that is not an unstamped probe");

endmodule

>>> rtl/core/pqtp_classify.sv
// Packet classifier: probe / query / path trace decode and stamp request.
module pqtp_classify (
   input  pqtp_pkg::req_word_type      item,
   input  logic [pqtp_pkg::UDP_W-1:0]  probe_udp,
   output pqtp_pkg::class_info_type    info
);

   logic                           is_udp4;
   logic [pqtp_pkg::UDP_W:0]       port_probe;
   logic [pqtp_pkg::UDP_W:0]       port_query;
   logic [pqtp_pkg::UDP_W:0]       port_path;
   logic [pqtp_pkg::UDP_W:0]       udp_ext;
   logic [pqtp_pkg::CLASS_W-1:0]   cls;
   logic                           stamp;

   // query/path ports are formed one bit wider, no wrap
   assign port_probe = {1'b0, probe_udp};
   assign port_query = port_probe + 17'd1;
   assign port_path  = port_probe + 17'd2;
   assign udp_ext    = {1'b0, item.udp_dst_port};

   assign is_udp4 = (item.ether_type == pqtp_pkg::ETHER_IPV4) &&
                    (item.ip_proto == pqtp_pkg::IP_PROTO_UDP);

   always_comb begin
      cls = pqtp_pkg::CLS_OTHER;
      if (is_udp4) begin
         if (udp_ext == port_probe)      cls = pqtp_pkg::CLS_PROBE;
         else if (udp_ext == port_query) cls = pqtp_pkg::CLS_QUERY;
         else if (udp_ext == port_path)  cls = pqtp_pkg::CLS_PATH;
      end
      stamp = ((cls == pqtp_pkg::CLS_PROBE) || (cls == pqtp_pkg::CLS_QUERY)) &&
              (item.header_switch_id == '0);
   end

   assign info.cls   = cls;
   assign info.stamp = stamp;
   assign info.walk  = (cls == pqtp_pkg::CLS_PROBE) && stamp;

endmodule
